// ===== src/whp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package whp_pkg;

  localparam int unsigned NumLanes = 2;   // lane 0: base 31, lane 1: base 53
  localparam int unsigned HashW    = 30;
  localparam int unsigned SymW     = 8;
  localparam int unsigned WinLenW  = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 64;

  // Barrett reduction widths: k = HashW, mu = floor(2^(2k) / m)
  localparam int unsigned ProdW = 2 * HashW;
  localparam int unsigned MuW   = HashW + 1;
  localparam int unsigned RemW  = HashW + 2;

  localparam logic [SymW-1:0] SymOffset = 8'd96;

  localparam logic [NumLanes-1:0][HashW-1:0] Modulus = {30'd1000000007, 30'd1000000009};
  localparam logic [NumLanes-1:0][HashW-1:0] Base    = {30'd53, 30'd31};
  localparam logic [NumLanes-1:0][HashW-1:0] BaseInv = {30'd56603774, 30'd838709685};

  localparam logic [63:0] MuFullA = 64'h1000_0000_0000_0000 / 64'd1000000009;
  localparam logic [63:0] MuFullB = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [NumLanes-1:0][MuW-1:0] Mu = {MuW'(MuFullB), MuW'(MuFullA)};

  typedef logic [NumLanes-1:0][HashW-1:0] lane_word_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LENGTH,
    REG_SCALE_A,
    REG_SCALE_B,
    REG_TOP_POWER_A,
    REG_TOP_POWER_B
  } cfg_reg_e;

  // operand pair fed to the modular multiplier
  typedef enum logic [2:0] {
    OP_VAL_RISE,   // symbol value * rising power
    OP_RISE_BASE,  // rising power * base
    OP_VAL_TOP,    // symbol value * top power
    OP_DIFF_INV,   // (hash - oldest) * base inverse
    OP_SCALE       // hash * scale
  } mul_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_MUL,
    ST_F_POW,
    ST_F_W1,
    ST_F_W2,
    ST_F_ACC,
    ST_F_STEP,
    ST_S_RD,
    ST_S_SUB,
    ST_S_INV,
    ST_S_W1,
    ST_S_TOP,
    ST_S_W2,
    ST_S_ACC,
    ST_C_MUL,
    ST_C_W1,
    ST_C_W2,
    ST_C_W3,
    ST_OUT
  } state_e;

  typedef struct packed {
    lane_word_t scale;
    lane_word_t top_power;
  } cfg_t;

  typedef struct packed {
    logic    capture;
    mul_op_e op;
    logic    sub_en;
    logic    top_en;
    logic    fill_acc;
    logic    fill_step;
    logic    slide_step;
    logic    out_load;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic filling;
    logic fill_done;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/window_double_poly_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window double polynomial hash (bases 31 and 53, moduli 1e9+9 and 1e9+7).
// Input stream: one byte per request on s_axis, tlast marks the final byte of a
// string. Output stream: one request per byte once the window is full, carrying
// both scaled window hashes; tlast repeats the input tlast. A string that ends
// before the window fills produces nothing.
// Config: cfg_we_i writes cfg_index_i (0 window length, 1/2 scale a/b,
// 3/4 top power a/b) at the clock edge; write only while the block is idle.
// Timing: one byte at a time through a shared 4-stage Barrett multiplier per
// lane. A new byte is accepted only in the idle state, once the last byte's
// result has gone into the string state or the output register. The multiplier
// pipeline and the read of the oldest byte from the window RAM set how long
// each byte takes.
// Stalls: a result waits in the output register; a new byte is accepted meanwhile,
// and that byte's result holds in the last stage until the register frees.
// Reset: config registers back to 1, string state cleared. The window RAM is not
// cleared; it is always written before it is read.
module window_double_poly_hash import whp_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [7:0] symbol
  input  wire logic                s_axis_tlast,   // last
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [29:0] hash_a, [59:30] hash_b, pad
  output logic                     m_axis_tlast,   // end_of_string
  // config write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [HashW-1:0]    cfg_wdata_i
);

  localparam int unsigned FillW = $clog2(MAX_WINDOW + 1);

  logic [WinLenW-1:0] win_len_q;
  cfg_t               cfg_q;
  logic [FillW-1:0]   len_eff;
  cmd_t               cmd;
  sts_t               sts;
  lane_word_t         out_hash;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q       <= WinLenW'(1);
      cfg_q.scale     <= {NumLanes{HashW'(1)}};
      cfg_q.top_power <= {NumLanes{HashW'(1)}};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: win_len_q          <= cfg_wdata_i[WinLenW-1:0];
        REG_SCALE_A:       cfg_q.scale[0]     <= cfg_wdata_i;
        REG_SCALE_B:       cfg_q.scale[1]     <= cfg_wdata_i;
        REG_TOP_POWER_A:   cfg_q.top_power[0] <= cfg_wdata_i;
        REG_TOP_POWER_B:   cfg_q.top_power[1] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero length acts as 1, oversize lengths clamp to the RAM depth
  always_comb begin
    priority if (win_len_q == '0) begin
      len_eff = FillW'(1);
    end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
      len_eff = FillW'(MAX_WINDOW);
    end else begin
      len_eff = FillW'(win_len_q);
    end
  end

  whp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  whp_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg_q),
    .win_len_i   (len_eff),
    .in_symbol_i (s_axis_tdata[SymW-1:0]),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_hash_o  (out_hash),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutDataW-NumLanes*HashW){1'b0}}, out_hash[1], out_hash[0]};

endmodule

`default_nettype wire

// ===== src/whp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module whp_ctrl import whp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // multiplier results are read from res_q, after the prod, quo/plo1 and qm/plo2 registers
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = OP_SCALE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.filling ? ST_F_MUL : ST_S_RD;
        end
      end
      ST_F_MUL: begin
        cmd_o.op = OP_VAL_RISE;
        state_d  = ST_F_POW;
      end
      ST_F_POW: begin
        cmd_o.op = OP_RISE_BASE;
        state_d  = ST_F_W1;
      end
      ST_F_W1: state_d = ST_F_W2;
      ST_F_W2: state_d = ST_F_ACC;
      ST_F_ACC: begin
        cmd_o.fill_acc = 1'b1;
        state_d        = ST_F_STEP;
      end
      ST_F_STEP: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_done) begin
          state_d = ST_C_MUL;
        end else begin
          cmd_o.clear = sts_i.last;
          state_d     = ST_IDLE;
        end
      end
      ST_S_RD: begin
        cmd_o.op = OP_VAL_TOP;
        state_d  = ST_S_SUB;
      end
      ST_S_SUB: begin
        cmd_o.sub_en = 1'b1;
        state_d      = ST_S_INV;
      end
      ST_S_INV: begin
        cmd_o.op = OP_DIFF_INV;
        state_d  = ST_S_W1;
      end
      ST_S_W1: state_d = ST_S_TOP;
      ST_S_TOP: begin
        cmd_o.top_en = 1'b1;
        state_d      = ST_S_W2;
      end
      ST_S_W2: state_d = ST_S_ACC;
      ST_S_ACC: begin
        cmd_o.slide_step = 1'b1;
        state_d          = ST_C_MUL;
      end
      ST_C_MUL: state_d = ST_C_W1;
      ST_C_W1:  state_d = ST_C_W2;
      ST_C_W2:  state_d = ST_C_W3;
      ST_C_W3:  state_d = ST_OUT;
      ST_OUT: begin
        // scale product is reissued every cycle, so it stays valid while stalled
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = sts_i.last;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/whp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module whp_dp import whp_pkg::*; #(
  parameter  int unsigned MAX_WINDOW = 1024,
  localparam int unsigned FillW      = $clog2(MAX_WINDOW + 1),
  localparam int unsigned AddrW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  input  wire cfg_t             cfg_i,
  input  wire logic [FillW-1:0] win_len_i,
  input  wire logic [SymW-1:0]  in_symbol_i,
  input  wire logic             in_last_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output lane_word_t            out_hash_o,
  output logic                  out_last_o
);

  function automatic logic [HashW-1:0] sym_val(input logic [SymW-1:0] s,
                                               input logic [HashW-1:0] m);
    logic [HashW-1:0] ext;
    ext = {{(HashW-SymW){1'b0}}, s};
    return (s >= SymOffset) ? ext - HashW'(SymOffset) : m - (HashW'(SymOffset) - ext);
  endfunction

  function automatic logic [HashW-1:0] mod_add(input logic [HashW-1:0] a,
                                               input logic [HashW-1:0] b,
                                               input logic [HashW-1:0] m);
    logic [HashW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, m}) ? HashW'(s - {1'b0, m}) : s[HashW-1:0];
  endfunction

  function automatic logic [HashW-1:0] mod_sub(input logic [HashW-1:0] a,
                                               input logic [HashW-1:0] b,
                                               input logic [HashW-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  // item registers
  logic [SymW-1:0] sym_q;
  logic            last_q;
  lane_word_t      val_q, diff_q, term_q;

  // string state
  lane_word_t       hash_q, rise_q;
  logic [FillW-1:0] fill_q;
  logic [AddrW-1:0] wp_q;

  // window store
  logic [SymW-1:0]  mem [MAX_WINDOW];
  logic [SymW-1:0]  rd_q;
  logic [AddrW-1:0] rd_addr, wr_addr, wp_next;
  logic [AddrW:0]   wp_inc;
  logic             wr_en;

  // modular multiplier pipeline, one per lane
  lane_word_t                       opx, opy, res_d, res_q;
  logic [NumLanes-1:0][ProdW-1:0]   prod_d, prod_q;
  logic [NumLanes-1:0][2*MuW-1:0]   mu_prod;
  logic [NumLanes-1:0][MuW-1:0]     quo_q;
  logic [NumLanes-1:0][ProdW:0]     qm_prod;
  logic [NumLanes-1:0][RemW-1:0]    plo1_q, plo2_q, qm_q, rem;

  // output register
  logic       out_valid_q, out_last_q;
  lane_word_t out_hash_q;

  // ---------------- multiplier ----------------
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      unique case (cmd_i.op)
        OP_VAL_RISE: begin
          opx[l] = val_q[l];
          opy[l] = rise_q[l];
        end
        OP_RISE_BASE: begin
          opx[l] = rise_q[l];
          opy[l] = Base[l];
        end
        OP_VAL_TOP: begin
          opx[l] = val_q[l];
          opy[l] = cfg_i.top_power[l];
        end
        OP_DIFF_INV: begin
          opx[l] = diff_q[l];
          opy[l] = BaseInv[l];
        end
        OP_SCALE: begin
          opx[l] = hash_q[l];
          opy[l] = cfg_i.scale[l];
        end
        default: begin
          opx[l] = hash_q[l];
          opy[l] = cfg_i.scale[l];
        end
      endcase
      prod_d[l]  = {{HashW{1'b0}}, opx[l]} * {{HashW{1'b0}}, opy[l]};
      mu_prod[l] = {{MuW{1'b0}}, prod_q[l][ProdW-1:HashW-1]} * {{MuW{1'b0}}, Mu[l]};
      qm_prod[l] = {{HashW{1'b0}}, quo_q[l]} * {{MuW{1'b0}}, Modulus[l]};
      // Barrett quotient is short by at most two
      rem[l]     = plo2_q[l] - qm_q[l];
      if (rem[l] >= RemW'({Modulus[l], 1'b0})) begin
        res_d[l] = HashW'(rem[l] - RemW'({Modulus[l], 1'b0}));
      end else if (rem[l] >= RemW'(Modulus[l])) begin
        res_d[l] = HashW'(rem[l] - RemW'(Modulus[l]));
      end else begin
        res_d[l] = rem[l][HashW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      prod_q[l] <= prod_d[l];
      quo_q[l]  <= mu_prod[l][2*MuW-1:MuW];
      plo1_q[l] <= prod_q[l][RemW-1:0];
      qm_q[l]   <= qm_prod[l][RemW-1:0];
      plo2_q[l] <= plo1_q[l];
      res_q[l]  <= res_d[l];
    end
  end

  // ---------------- item registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q  <= in_symbol_i;
      last_q <= in_last_i;
      for (int l = 0; l < NumLanes; l++) begin
        val_q[l] <= sym_val(in_symbol_i, Modulus[l]);
      end
    end
    if (cmd_i.sub_en) begin
      for (int l = 0; l < NumLanes; l++) begin
        diff_q[l] <= mod_sub(hash_q[l], sym_val(rd_q, Modulus[l]), Modulus[l]);
      end
    end
    if (cmd_i.top_en) begin
      term_q <= res_q;
    end
  end

  // ---------------- window store ----------------
  assign rd_addr = (32'(wp_q) >= 32'(win_len_i)) ? '0 : wp_q;
  assign wp_inc  = {1'b0, rd_addr} + (AddrW+1)'(1);
  assign wp_next = (32'(wp_inc) >= 32'(win_len_i)) ? '0 : wp_inc[AddrW-1:0];
  assign wr_en   = cmd_i.fill_step | cmd_i.slide_step;
  assign wr_addr = cmd_i.fill_step ? fill_q[AddrW-1:0] : rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= sym_q;
    end
    rd_q <= mem[rd_addr];
  end

  // ---------------- string state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      rise_q <= {NumLanes{HashW'(1)}};
      fill_q <= '0;
      wp_q   <= '0;
    end else if (cmd_i.clear) begin
      hash_q <= '0;
      rise_q <= {NumLanes{HashW'(1)}};
      fill_q <= '0;
      wp_q   <= '0;
    end else begin
      if (cmd_i.fill_acc) begin
        for (int l = 0; l < NumLanes; l++) begin
          hash_q[l] <= mod_add(hash_q[l], res_q[l], Modulus[l]);
        end
      end
      if (cmd_i.fill_step) begin
        rise_q <= res_q;
        fill_q <= fill_q + FillW'(1);
        if (sts_o.fill_done) begin
          wp_q <= '0;
        end
      end
      if (cmd_i.slide_step) begin
        for (int l = 0; l < NumLanes; l++) begin
          hash_q[l] <= mod_add(res_q[l], term_q[l], Modulus[l]);
        end
        fill_q <= win_len_i;
        wp_q   <= wp_next;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hash_q <= res_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hash_o  = out_hash_q;
  assign out_last_o  = out_last_q;

  assign sts_o.filling   = fill_q < win_len_i;
  assign sts_o.fill_done = (fill_q + FillW'(1)) == win_len_i;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

// ===== src/whp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module whp_checker import whp_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  // one byte in flight: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a byte is in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // both hashes reduced, padding clear
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[29:0] < Modulus[0]) &&
                      (m_axis_tdata[59:30] < Modulus[1]) &&
                      (m_axis_tdata[63:60] == 4'd0))
    else $error("hash out of range");

  // no result can appear right after a byte is taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind window_double_poly_hash whp_checker u_whp_checker (.*);

`default_nettype wire
